// File: rtl/pcs_pkg.sv
// Shared constants and types for the piecewise contrast stretch core.
package pcs_pkg;

    // Item kinds carried in tuser bit 0
    localparam logic OP_GATHER = 1'b0;
    localparam logic OP_MAP    = 1'b1;

    // Grey-level and arithmetic widths
    localparam int LEVEL_W = 8;
    localparam int PROD5_W = 18;            // gap times reciprocal of five
    localparam int NUM_W   = 19;            // 1275 * (pixel - low)
    localparam int QUOT_W  = 10;            // quotient never reaches 1024
    localparam int REM_W   = LEVEL_W + 1;
    localparam int CNT_W   = $clog2(QUOT_W + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 8'd0;
    localparam logic [NUM_W-1:0]   BAND_SCALE = 19'd1275;
    // floor(x/5) == (x*205) >> 10 for every x below 1024
    localparam logic [PROD5_W-1:0] RECIP5     = 18'd205;
    localparam int                 RECIP5_SH  = 10;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } pcs_div_status_t;

endpackage

// File: rtl/pcs_serial_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, numerator shifted in bit-serially.
module pcs_serial_div
    import pcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     numer,
    input  logic [LEVEL_W-1:0]   divisor,
    output logic [QUOT_W-1:0]    quotient,
    output pcs_div_status_t      status
);

    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic               done_reg, done_next;
    logic [REM_W-1:0]   rem_reg,  rem_next;
    logic [QUOT_W-1:0]  nsh_reg,  nsh_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [LEVEL_W-1:0] dvs_reg,  dvs_next;

    logic [REM_W:0]     trial;
    logic               fits;

    // Bring down the next numerator bit and try one subtraction
    assign trial = {rem_reg, nsh_reg[QUOT_W-1]};
    assign fits  = (trial >= {2'b00, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        nsh_next  = nsh_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            // Upper numerator bits are already below the divisor
            cnt_next  = CNT_W'(QUOT_W);
            rem_next  = numer[NUM_W-1:QUOT_W];
            nsh_next  = numer[QUOT_W-1:0];
            dvs_next  = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            rem_next  = fits ? REM_W'(trial - {2'b00, dvs_reg}) : trial[REM_W-1:0];
            nsh_next  = {nsh_reg[QUOT_W-2:0], 1'b0};
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Hold control state under reset; datapath needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        nsh_reg  <= nsh_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign quotient    = quot_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

// File: rtl/piecewise_contrast_stretch_core.sv
// Top level of the piecewise contrast stretch: statistics, thresholds and mapping sequencer.
//
//  channel | direction | signals                          | carries
//  --------+-----------+----------------------------------+-------------------------------
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser| pixel; opcode, frame_start
//  m_*     | out       | m_tvalid m_tready m_tdata        | mapped_pixel
//
// A gather item passes through the transfer and a threshold update. A map item goes
// through setup and hold when the pixel falls outside the middle band; inside it, the item
// also waits in the divide state while the 10-step radix-2 serial divider runs.
// Reset clears the running minimum to 255, the maximum to 0 and empties the output.
// A stalled output register lets gather items pass, but the next map result waits
// in the sequencer, with input blocked, until the output register is free.
module piecewise_contrast_stretch_core
    import pcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] pixel
    input  logic [1:0]         s_tuser,   // [0] opcode, [1] frame_start
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata    // [7:0] mapped_pixel
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATS,
        ST_SETUP,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t               state_reg;
    logic [LEVEL_W-1:0]   min_reg, max_reg;
    logic [LEVEL_W-1:0]   low_reg, high_reg, gap_reg;
    logic [LEVEL_W-1:0]   pix_reg;
    logic [LEVEL_W-1:0]   res_reg;
    logic                 out_valid_reg;
    logic [LEVEL_W-1:0]   out_data_reg;

    logic                 in_xfer;
    logic [LEVEL_W-1:0]   gap_c, low_c, high_c, diff_c;
    logic [PROD5_W-1:0]   fifth_prod, two_fifth_prod;
    logic [NUM_W-1:0]     num_c;
    logic                 div_start;
    logic [QUOT_W-1:0]    div_quot;
    pcs_div_status_t      div_stat;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // Band thresholds from the gathered range; an inverted range counts as flat
    assign gap_c          = (max_reg >= min_reg) ? (max_reg - min_reg) : LEVEL_MIN;
    assign fifth_prod     = {{(PROD5_W-LEVEL_W){1'b0}}, gap_c} * RECIP5;
    assign two_fifth_prod = {{(PROD5_W-LEVEL_W-1){1'b0}}, gap_c, 1'b0} * RECIP5;
    assign low_c          = min_reg + fifth_prod[RECIP5_SH +: LEVEL_W];
    assign high_c         = min_reg + two_fifth_prod[RECIP5_SH +: LEVEL_W];

    // Scaled offset into the middle band
    assign diff_c    = pix_reg - low_reg;
    assign num_c     = {{(NUM_W-LEVEL_W){1'b0}}, diff_c} * BAND_SCALE;
    assign div_start = (state_reg == ST_SETUP) && (pix_reg >= low_reg) && (pix_reg < high_reg);

    pcs_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (num_c),
        .divisor  (gap_reg),
        .quotient (div_quot),
        .status   (div_stat)
    );

    // Sequence items and hold statistics, thresholds and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= LEVEL_MAX;
            max_reg       <= LEVEL_MIN;
            low_reg       <= LEVEL_MAX;
            high_reg      <= LEVEL_MAX;
            gap_reg       <= LEVEL_MIN;
            res_reg       <= LEVEL_MIN;
            out_valid_reg <= 1'b0;
            out_data_reg  <= LEVEL_MIN;
        end
        else
        begin
            // Drop the result once the consumer takes it, unless a new one loads
            if (out_valid_reg && m_tready && (state_reg != ST_HOLD))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (s_tuser[0] == OP_GATHER)
                        begin
                            if (s_tuser[1])
                            begin
                                min_reg <= s_tdata;
                                max_reg <= s_tdata;
                            end
                            else
                            begin
                                if (s_tdata < min_reg)
                                begin
                                    min_reg <= s_tdata;
                                end
                                if (s_tdata > max_reg)
                                begin
                                    max_reg <= s_tdata;
                                end
                            end
                            state_reg <= ST_STATS;
                        end
                        else
                        begin
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                ST_STATS:
                begin
                    low_reg   <= low_c;
                    high_reg  <= high_c;
                    gap_reg   <= gap_c;
                    state_reg <= ST_IDLE;
                end
                ST_SETUP:
                begin
                    if (pix_reg < low_reg)
                    begin
                        res_reg   <= LEVEL_MIN;
                        state_reg <= ST_HOLD;
                    end
                    else if (pix_reg >= high_reg)
                    begin
                        res_reg   <= LEVEL_MAX;
                        state_reg <= ST_HOLD;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // Saturate the quotient to a grey level
                    if (div_stat.done)
                    begin
                        res_reg   <= (div_quot[QUOT_W-1:LEVEL_W] != '0) ?
                                     LEVEL_MAX : div_quot[LEVEL_W-1:0];
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture the pixel of each transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pix_reg <= s_tdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Divider finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // No new item is taken while the divider still runs
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_stat.busy)
        else $error("input ready while divider busy");

    // Gathered statistics stay ordered when thresholds are rebuilt
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STATS) |-> (min_reg <= max_reg))
        else $error("minimum above maximum after gather");

    // A map transfer always leads to the setup step
    a_map_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (s_tuser[0] == OP_MAP)) |=> (state_reg == ST_SETUP))
        else $error("map transfer did not enter setup");

endmodule

// File: test/piecewise_contrast_stretch_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_contrast_stretch_core: gather/map frames with a level predictor.
module piecewise_contrast_stretch_core_tb
    import pcs_pkg::*;
();

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 1450;
    localparam int TAIL_CYCLES  = 24;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [7:0] pixel;
        logic [7:0] level;
    } level_expect_t;

    // Predicts stretched levels from the running statistics and checks them in order
    class level_scoreboard;
        logic [7:0]    min_lvl;
        logic [7:0]    max_lvl;
        level_expect_t expected_levels[$];
        int            errors;

        function new();
            min_lvl = LEVEL_MAX;
            max_lvl = LEVEL_MIN;
            errors  = 0;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR %0t: %s", $realtime, msg);
            errors++;
        endtask

        function logic [7:0] predict_level(logic [7:0] pix);
            int unsigned gap;
            int unsigned low_edge;
            int unsigned high_edge;
            int unsigned quot;
            gap       = (max_lvl >= min_lvl) ? max_lvl - min_lvl : 0;
            low_edge  = min_lvl + gap / 5;
            high_edge = min_lvl + (2 * gap) / 5;
            if (pix < low_edge)
                return LEVEL_MIN;
            if (pix < high_edge)
            begin
                // middle band is only non-empty when gap is at least three
                quot = (BAND_SCALE * (pix - low_edge)) / gap;
                return (quot > LEVEL_MAX) ? LEVEL_MAX : quot[7:0];
            end
            return LEVEL_MAX;
        endfunction

        // Update statistics on a gather transfer, queue a level on a map transfer
        function void note_item(logic op, logic frame_start, logic [7:0] pix);
            level_expect_t entry;
            if (op == OP_GATHER)
            begin
                if (frame_start)
                begin
                    min_lvl = pix;
                    max_lvl = pix;
                end
                else
                begin
                    if (pix < min_lvl)
                        min_lvl = pix;
                    if (pix > max_lvl)
                        max_lvl = pix;
                end
            end
            else
            begin
                entry.pixel = pix;
                entry.level = predict_level(pix);
                expected_levels.push_back(entry);
            end
        endfunction

        task check_level(logic [7:0] got);
            level_expect_t entry;
            if (expected_levels.size() == 0)
                report_mismatch($sformatf("unexpected result %0d", got));
            else
            begin
                entry = expected_levels.pop_front();
                if (got !== entry.level)
                    report_mismatch($sformatf("pixel %0d: mapped_pixel %0d, expected %0d",
                                              entry.pixel, got, entry.level));
            end
        endtask

        task close_out();
            while (expected_levels.size() != 0)
            begin
                report_mismatch($sformatf("missing result for pixel %0d",
                                          expected_levels[0].pixel));
                void'(expected_levels.pop_front());
            end
        endtask

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // [7:0] pixel
    logic [1:0] s_tuser  = 2'd0;   // [0] opcode, [1] frame_start
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] mapped_pixel

    level_scoreboard sb;
    int              items_sent   = 0;
    int              cycle_count  = 0;
    bit              steady_source = 1'b0;

    piecewise_contrast_stretch_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Generate the clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Stop the run at the cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("piecewise_contrast_stretch_core_tb NOT OK");
            $finish;
        end
    end

    // Observe both channels and feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_item(s_tuser[0], s_tuser[1], s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_level(m_tdata);
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Stall the result channel at random, with calm stretches in between
    initial
    begin : result_sink
        int stall_len;
        int calm_len;
        int r;
        stall_len = 0;
        calm_len  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (calm_len > 0)
            begin
                calm_len--;
                m_tready <= 1'b1;
            end
            else if (stall_len > 0)
            begin
                stall_len--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm_len = $urandom_range(50, 300);
                else if (r < 35)
                    stall_len = gap_length();
            end
        end
    end

    // Present one item after a random gap and hold it until the transfer
    task send_item(logic op, logic frame_start, logic [7:0] pix);
        int gap;
        gap = steady_source ? 0 : gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {frame_start, op};
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and hold off until every queued level has come back
    task drain_levels();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One gather pass and one map pass; a broken frame mixes in noise
    task run_frame(int n_pix, bit broken);
        int         base;
        int         top;
        int         span;
        int         lo_map;
        int         hi_map;
        int         r;
        int         i;
        bit         skip_start;
        logic [7:0] pix;
        base = $urandom_range(0, 255);
        r    = $urandom_range(0, 99);
        if (r < 15)
            span = 0;
        else if (r < 40)
            span = $urandom_range(1, 8);
        else if (r < 75)
            span = $urandom_range(9, 80);
        else
            span = 255;
        top        = (base + span > 255) ? 255 : base + span;
        lo_map     = (base > 3) ? base - 3 : 0;
        hi_map     = (top < 252) ? top + 3 : 255;
        skip_start = broken && ($urandom_range(0, 1) == 1);

        // Gather pass
        for (i = 0; i < n_pix; i++)
        begin
            pix = 8'($urandom_range(base, top));
            send_item(OP_GATHER, (i == 0) && !skip_start, pix);
        end

        // Map pass
        for (i = 0; i < n_pix; i++)
        begin
            if ($urandom_range(0, 99) < 20)
                pix = 8'($urandom_range(0, 255));
            else
                pix = 8'($urandom_range(lo_map, hi_map));
            if (broken && ($urandom_range(0, 9) == 0))
                send_item(OP_GATHER, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            send_item(OP_MAP, broken ? 1'($urandom_range(0, 1)) : 1'b0, pix);
        end
    endtask

    initial
    begin : stimulus
        int frame_idx;
        int n_pix;
        sb = new();

        // Hold reset, then release it
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Map before any gather: statistics are inverted, so the frame counts as flat
        send_item(OP_MAP, 1'b0, 8'd0);
        send_item(OP_MAP, 1'b1, 8'd128);
        send_item(OP_MAP, 1'b0, 8'd255);

        // Full-range frame: probe both band edges
        send_item(OP_GATHER, 1'b1, 8'd0);
        send_item(OP_GATHER, 1'b0, 8'd255);
        send_item(OP_MAP, 1'b0, 8'd0);
        send_item(OP_MAP, 1'b0, 8'd50);
        send_item(OP_MAP, 1'b0, 8'd51);
        send_item(OP_MAP, 1'b0, 8'd76);
        send_item(OP_MAP, 1'b1, 8'd101);
        send_item(OP_MAP, 1'b0, 8'd102);
        send_item(OP_MAP, 1'b0, 8'd255);

        // Flat frame, with pixels below, at and above the level
        send_item(OP_GATHER, 1'b1, 8'd100);
        send_item(OP_MAP, 1'b0, 8'd99);
        send_item(OP_MAP, 1'b0, 8'd100);
        send_item(OP_MAP, 1'b0, 8'd170);

        // Narrow frame with the smallest non-empty middle band
        steady_source = 1'b1;
        send_item(OP_GATHER, 1'b1, 8'd13);
        send_item(OP_GATHER, 1'b0, 8'd10);
        send_item(OP_MAP, 1'b0, 8'd10);
        send_item(OP_MAP, 1'b0, 8'd11);
        send_item(OP_MAP, 1'b0, 8'd9);
        steady_source = 1'b0;
        drain_levels();

        // Random frames, most of them well formed
        frame_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            steady_source = ($urandom_range(0, 4) == 0);
            n_pix = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                 : $urandom_range(13, 40);
            run_frame(n_pix, $urandom_range(0, 9) == 0);
            frame_idx++;
            if (frame_idx % 25 == 0)
                drain_levels();
        end

        // Wait out the remaining results and the pipeline tail
        drain_levels();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("piecewise_contrast_stretch_core_tb OK");
        else
            $display("piecewise_contrast_stretch_core_tb NOT OK");
        $finish;
    end

endmodule
